@@ hw/rtl/bots_pkg.sv @@
// ----------------------------------------------------------------------------
// bots_pkg
// Types and codes shared by the bulk-only transport sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bots_pkg;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  localparam logic [15:0] CbwLength = 16'd31;
  localparam logic [15:0] CswLength = 16'd13;
  localparam logic [7:0]  FlagDataIn = 8'h80;
  localparam logic [7:0]  FlagDataOut = 8'h00;

  typedef enum logic [1:0] {
    CFG_IN_EP  = 2'd0,
    CFG_OUT_EP = 2'd1,
    CFG_IFACE  = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_START    = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    OUTC_OK    = 2'd0,
    OUTC_STALL = 2'd1,
    OUTC_ERROR = 2'd2,
    OUTC_OTHER = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ACT_CBW      = 3'd0,
    ACT_DOUT     = 3'd1,
    ACT_DIN      = 3'd2,
    ACT_CSW      = 3'd3,
    ACT_CLEAR    = 3'd4,
    ACT_RESET    = 3'd5,
    ACT_COMPLETE = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_CBW         = 4'd1,
    PH_CBW_CLEAR   = 4'd2,
    PH_DATA        = 4'd3,
    PH_DATA_CLEAR  = 4'd4,
    PH_CSW_RECOVER = 4'd5,
    PH_CSW         = 4'd6,
    PH_RESET       = 4'd7,
    PH_CLR_IN      = 4'd8,
    PH_CLR_OUT     = 4'd9
  } phase_t;

  typedef struct packed {
    logic [3:0] in_endpoint;
    logic [3:0] out_endpoint;
    logic [7:0] interface_number;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [3:0]  unit;
    logic [4:0]  command_length;
    logic [15:0] transfer_length;
    logic        is_write;
    outcome_t    outcome;
    logic [15:0] bytes_done;
    logic        status_signature_ok;
    logic [7:0]  status_byte;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  endpoint;
    logic [15:0] request_length;
    logic [7:0]  request_index;
    logic [7:0]  direction_flags;
    logic [3:0]  cbw_unit;
    logic [4:0]  cbw_command_length;
    logic [15:0] cbw_data_length;
    logic        finished;
    logic        passed;
  } res_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/bots_cfg.sv @@
// ----------------------------------------------------------------------------
// bots_cfg
// Configuration registers: endpoint numbers and interface index.
// ----------------------------------------------------------------------------
`default_nettype none

module bots_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [7:0]             cfg_data,
  output bots_pkg::cfg_t              cfg
);
  import bots_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_endpoint      <= 4'd1;
      cfg.out_endpoint     <= 4'd2;
      cfg.interface_number <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_IN_EP:  cfg.in_endpoint      <= cfg_data[3:0];
        CFG_OUT_EP: cfg.out_endpoint     <= cfg_data[3:0];
        CFG_IFACE:  cfg.interface_number <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bots_in.sv @@
// ----------------------------------------------------------------------------
// bots_in
// Input register: captures one item from the slave stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bots_in (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [bots_pkg::InDataW-1:0]  s_tdata,
  input  wire logic                          s_tuser,
  input  wire logic                          advance,
  output      logic                          item_valid,
  output bots_pkg::in_item_t                 item
);
  import bots_pkg::*;

  logic take;

  assign s_tready = !item_valid || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.operation           <= op_t'(s_tuser);
      item.unit                <= s_tdata[3:0];
      item.command_length      <= s_tdata[8:4];
      item.transfer_length     <= s_tdata[24:9];
      item.is_write            <= s_tdata[25];
      item.outcome             <= outcome_t'(s_tdata[27:26]);
      item.bytes_done          <= s_tdata[43:28];
      item.status_signature_ok <= s_tdata[44];
      item.status_byte         <= s_tdata[52:45];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bots_ctrl.sv @@
// ----------------------------------------------------------------------------
// bots_ctrl
// Phase register, saved command and next-action selection.
// ----------------------------------------------------------------------------
`default_nettype none

module bots_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire bots_pkg::cfg_t      cfg,
  input  wire bots_pkg::in_item_t  item,
  output      logic                has_result,
  output bots_pkg::res_item_t      result
);
  import bots_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic        saved_write;
  logic [15:0] saved_length;
  logic [3:0]  saved_unit;
  logic [4:0]  saved_command_length;

  logic ok;
  logic stall;
  logic status_zero;
  logic early_status;

  function automatic res_item_t mk(action_t a, logic [3:0] ep, logic [15:0] len,
                                   logic [7:0] idx);
    res_item_t r;
    r                = '0;
    r.action         = a;
    r.endpoint       = ep;
    r.request_length = len;
    r.request_index  = idx;
    return r;
  endfunction

  function automatic res_item_t mk_done(logic pass);
    res_item_t r;
    r          = mk(ACT_COMPLETE, 4'd0, 16'd0, 8'd0);
    r.finished = 1'b1;
    r.passed   = pass;
    return r;
  endfunction

  assign ok           = item.outcome == OUTC_OK;
  assign stall        = item.outcome == OUTC_STALL;
  assign status_zero  = item.status_byte == 8'd0;
  assign early_status = (item.bytes_done == CswLength) && item.status_signature_ok;

  // next phase
  always_comb begin
    phase_next = phase;
    if (item.operation == OP_START) begin
      phase_next = PH_CBW;
    end else begin
      case (phase)
        PH_CBW, PH_CBW_CLEAR: begin
          if (phase == PH_CBW && stall) phase_next = PH_CBW_CLEAR;
          else if (!ok && phase == PH_CBW_CLEAR) phase_next = PH_RESET;
          else if (!ok) phase_next = PH_IDLE;
          else if (saved_length != 16'd0) phase_next = PH_DATA;
          else phase_next = PH_CSW;
        end
        PH_DATA: begin
          if (stall) phase_next = PH_DATA_CLEAR;
          else if (!ok || early_status) phase_next = PH_IDLE;
          else phase_next = PH_CSW;
        end
        PH_DATA_CLEAR: phase_next = ok ? PH_CSW_RECOVER : PH_RESET;
        PH_CSW_RECOVER: phase_next = stall ? PH_RESET : PH_IDLE;
        PH_RESET:  phase_next = PH_CLR_IN;
        PH_CLR_IN: phase_next = PH_CLR_OUT;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // result item
  always_comb begin
    has_result = 1'b1;
    result     = '0;
    if (item.operation == OP_START) begin
      result                    = mk(ACT_CBW, cfg.out_endpoint, CbwLength, 8'd0);
      result.direction_flags    = item.is_write ? FlagDataOut : FlagDataIn;
      result.cbw_unit           = item.unit;
      result.cbw_command_length = item.command_length;
      result.cbw_data_length    = item.transfer_length;
    end else begin
      case (phase)
        PH_CBW, PH_CBW_CLEAR: begin
          if (phase == PH_CBW && stall) begin
            result = mk(ACT_CLEAR, cfg.out_endpoint, 16'd0, {4'd0, cfg.out_endpoint});
          end else if (!ok && phase == PH_CBW_CLEAR) begin
            result = mk(ACT_RESET, 4'd0, 16'd0, cfg.interface_number);
          end else if (!ok) begin
            result = mk_done(1'b0);
          end else if (saved_length != 16'd0) begin
            if (saved_write) result = mk(ACT_DOUT, cfg.out_endpoint, saved_length, 8'd0);
            else result = mk(ACT_DIN, cfg.in_endpoint, saved_length, 8'd0);
          end else begin
            result = mk(ACT_CSW, cfg.in_endpoint, CswLength, 8'd0);
          end
        end
        PH_DATA: begin
          if (stall) begin
            if (saved_write) begin
              result = mk(ACT_CLEAR, cfg.out_endpoint, 16'd0, {4'd0, cfg.out_endpoint});
            end else begin
              result = mk(ACT_CLEAR, cfg.in_endpoint, 16'd0, {4'd0, cfg.in_endpoint});
            end
          end else if (!ok) begin
            result = mk_done(1'b0);
          end else if (early_status) begin
            result = mk_done(status_zero);
          end else begin
            result = mk(ACT_CSW, cfg.in_endpoint, CswLength, 8'd0);
          end
        end
        PH_DATA_CLEAR: begin
          if (ok) result = mk(ACT_CSW, cfg.in_endpoint, CswLength, 8'd0);
          else result = mk(ACT_RESET, 4'd0, 16'd0, cfg.interface_number);
        end
        PH_CSW_RECOVER: begin
          if (stall) result = mk(ACT_RESET, 4'd0, 16'd0, cfg.interface_number);
          else result = mk_done(ok && status_zero);
        end
        PH_CSW:     result = mk_done(ok && status_zero);
        PH_RESET:   result = mk(ACT_CLEAR, cfg.in_endpoint, 16'd0, {4'd0, cfg.in_endpoint});
        PH_CLR_IN:  result = mk(ACT_CLEAR, cfg.out_endpoint, 16'd0, {4'd0, cfg.out_endpoint});
        PH_CLR_OUT: result = mk_done(1'b0);
        default:    has_result = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      saved_write          <= 1'b0;
      saved_length         <= 16'd0;
      saved_unit           <= 4'd0;
      saved_command_length <= 5'd0;
    end else if (advance) begin
      phase <= phase_next;
      if (item.operation == OP_START) begin
        saved_write          <= item.is_write;
        saved_length         <= item.transfer_length;
        saved_unit           <= item.unit;
        saved_command_length <= item.command_length;
      end
    end
  end

  // unit and command length are saved with the command but unused; the CBW takes them from the start item
  logic unused_saved;
  assign unused_saved = ^{saved_unit, saved_command_length};

endmodule

`default_nettype wire

@@ hw/rtl/bots_out.sv @@
// ----------------------------------------------------------------------------
// bots_out
// Result register driving the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bots_out (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire bots_pkg::res_item_t            result,
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [bots_pkg::OutDataW-1:0]  m_tdata,
  output      logic [2:0]                     m_tuser,
  output      logic                           free
);
  import bots_pkg::*;

  res_item_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tuser = held.action;
  assign m_tdata = {1'b0, held.passed, held.finished, held.cbw_data_length,
                    held.cbw_command_length, held.cbw_unit, held.direction_flags,
                    held.request_index, held.request_length, held.endpoint};

endmodule

`default_nettype wire

@@ hw/rtl/bulk_only_transport_sequencer.sv @@
// ----------------------------------------------------------------------------
// bulk_only_transport_sequencer
// Host-side bulk-only transport sequencer for mass storage commands.
// ----------------------------------------------------------------------------
// A start item (s_tuser low) latches a command and yields a send-CBW action;
// every completion item (s_tuser high) reports the outcome of the last action
// and yields the next one: data phase, CSW read, clear halt, reset or the final
// complete with its pass flag. A completion while idle yields nothing. Each
// item passes through an input register, one level of phase decode and a
// result register, so the block takes one item per clock while the master
// stream is not stalled, and each result leaves from the result register;
// the phase register is the only loop. Configuration writes are taken at any
// edge and must land while idle.
`default_nettype none

module bulk_only_transport_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // unit, command_length, transfer_length, is_write, outcome, bytes_done,
  // status_signature_ok, status_byte
  input  wire logic [bots_pkg::InDataW-1:0]  s_tdata,
  // operation
  input  wire logic                          s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // endpoint, request_length, request_index, direction_flags, cbw_unit,
  // cbw_command_length, cbw_data_length, finished, passed
  output      logic [bots_pkg::OutDataW-1:0] m_tdata,
  // action
  output      logic [2:0]                    m_tuser
);
  import bots_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  res_item_t result;
  logic      item_valid;
  logic      has_result;
  logic      out_free;
  logic      advance;

  assign advance = item_valid && out_free;

  bots_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bots_in u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bots_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cfg        (cfg),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  bots_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && has_result),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .free     (out_free)
  );

endmodule

`default_nettype wire
